### hdl/srtf_pkg.sv
package srtf_pkg;

	// Ready table size and derived widths
	localparam int MAX_JOBS = 32;
	localparam int SLOT_W   = $clog2(MAX_JOBS);
	localparam int LAST_W   = $clog2(MAX_JOBS + 1);

	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(MAX_JOBS - 1);
	localparam logic [LAST_W-1:0] NO_SLOT  = LAST_W'(MAX_JOBS);

	// Field widths
	localparam int ID_W    = 8;
	localparam int BURST_W = 16;
	localparam int TIME_W  = 32;
	localparam int ORDER_W = 32;
	localparam int QUANT_W = 8;

	// Item kind on the input side
	typedef enum logic {
		OP_ARRIVE   = 1'b0,
		OP_DISPATCH = 1'b1
	} op_t;

	// Result status codes
	typedef enum logic [2:0] {
		STAT_ACCEPTED  = 3'd0,
		STAT_REJECTED  = 3'd1,
		STAT_RAN       = 3'd2,
		STAT_IDLE      = 3'd3,
		STAT_COMPLETED = 3'd4
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_TAIL,
		S_RUN,
		S_TAT,
		S_DONE
	} state_t;

	// One ready-table entry
	typedef struct packed {
		logic [ID_W-1:0]    job;
		logic [BURST_W-1:0] remaining;
		logic [BURST_W-1:0] burst;
		logic [TIME_W-1:0]  arrived;
		logic [ORDER_W-1:0] order;
	} slot_rec_t;

	// Scan results handed from the pick unit to the sequencer
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] idx;
		logic              free_found;
		logic [SLOT_W-1:0] free_idx;
	} pick_t;

endpackage

### hdl/srtf_slot_mem.sv
module srtf_slot_mem (
	input  logic                          clk,
	input  logic                          we,
	input  logic [srtf_pkg::SLOT_W-1:0]   waddr,
	input  srtf_pkg::slot_rec_t           wdata,
	input  logic [srtf_pkg::SLOT_W-1:0]   raddr,
	output srtf_pkg::slot_rec_t           rdata
);
	import srtf_pkg::*;

	slot_rec_t mem_q [MAX_JOBS];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/srtf_pick.sv
module srtf_pick (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          cmp_en,
	input  logic                          cand_valid,
	input  logic [srtf_pkg::SLOT_W-1:0]   cand_idx,
	input  srtf_pkg::slot_rec_t           cand_rec,
	input  logic [srtf_pkg::LAST_W-1:0]   last_slot,
	output srtf_pkg::pick_t               pick,
	output srtf_pkg::slot_rec_t           best_rec
);
	import srtf_pkg::*;

	logic              found_q;
	logic [SLOT_W-1:0] idx_q;
	logic              free_found_q;
	logic [SLOT_W-1:0] free_idx_q;
	slot_rec_t         best_q;
	logic              cand_better;
	logic              take;
	logic              take_free;

	// Shared comparator: least remaining, then last run job, then earliest arrival
	always_comb begin
		if (!found_q) begin
			cand_better = 1'b1;
		end else if (cand_rec.remaining != best_q.remaining) begin
			cand_better = cand_rec.remaining < best_q.remaining;
		end else if (LAST_W'(cand_idx) == last_slot) begin
			cand_better = 1'b1;
		end else if (LAST_W'(idx_q) == last_slot) begin
			cand_better = 1'b0;
		end else begin
			cand_better = cand_rec.order < best_q.order;
		end
	end

	assign take      = cmp_en && cand_valid && cand_better;
	assign take_free = cmp_en && !cand_valid && !free_found_q;

	// Track best candidate and lowest free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			idx_q        <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
		end else if (clear) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (take) begin
				found_q <= 1'b1;
				idx_q   <= cand_idx;
			end
			if (take_free) begin
				free_found_q <= 1'b1;
				free_idx_q   <= cand_idx;
			end
		end
	end

	// Hold the full record of the best candidate
	always_ff @(posedge clk) begin
		if (take) begin
			best_q <= cand_rec;
		end
	end

	assign pick.found      = found_q;
	assign pick.idx        = idx_q;
	assign pick.free_found = free_found_q;
	assign pick.free_idx   = free_idx_q;
	assign best_rec        = best_q;

endmodule

### hdl/srtf_job_scheduler.sv
// Channel  | Dir | tdata (low bit first)                                     | tuser
// s_axis   | in  | job_id[7:0], burst[23:8]                                  | op
// m_axis   | out | run_id[7:0], time_now[39:8], time_left[55:40],            | status
//          |     | turnaround[87:56], waiting[119:88]                        |
// cfg      | in  | cfg_wdata = quantum, written when cfg_wen is high         |
//
// Each item is handled in steps: accept, stream the ready table through the
// single read port of the slot memory into one comparator, finish the last
// compare, then run, form turnaround and deliver.
// arst_n clears the valid bits, clock, order counter and last-run marker at once.
// A result waits in the output register; the block stalls before delivery only
// while a previous result is still not taken.
module srtf_job_scheduler (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [23:0]  s_axis_tdata,   // job_id, burst
	input  logic [0:0]   s_axis_tuser,   // op
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [119:0] m_axis_tdata,   // run_id, time_now, time_left, turnaround, waiting
	output logic [2:0]   m_axis_tuser,   // status
	input  logic         cfg_wen,
	input  logic [7:0]   cfg_wdata       // quantum
);
	import srtf_pkg::*;

	state_t state_q, state_d;

	logic [QUANT_W-1:0]  quantum_q;
	logic [MAX_JOBS-1:0] slot_valid_q;
	logic [ORDER_W-1:0]  order_q;
	logic [TIME_W-1:0]   clock_time_q;
	logic [LAST_W-1:0]   last_slot_q;

	logic               op_q;
	logic [ID_W-1:0]    id_q;
	logic [BURST_W-1:0] burst_q;

	logic [SLOT_W-1:0]  idx_q;
	logic [SLOT_W-1:0]  idx_s1;
	logic               cmp_en_s1;

	logic [BURST_W-1:0] rem_new_q;
	logic [TIME_W-1:0]  tat_q;

	logic               out_valid_q;
	logic [119:0]       out_data_q;
	logic [2:0]         out_user_q;

	logic accept;
	logic out_free;
	logic rd_issue;
	logic run_en;
	logic tat_en;
	logic done_fire;

	pick_t     pick;
	slot_rec_t best_rec;
	slot_rec_t rd_rec;
	slot_rec_t wr_rec;
	logic      mem_we;
	logic [SLOT_W-1:0] mem_waddr;

	logic               is_arrive;
	logic [BURST_W-1:0] q16;
	logic [BURST_W-1:0] run16;
	logic [BURST_W-1:0] rem_new;
	logic [TIME_W-1:0]  inc;
	logic [TIME_W:0]    sum;
	logic [TIME_W-1:0]  clock_new;

	logic [TIME_W-1:0]  wait_val;
	status_t            status;
	logic [ID_W-1:0]    run_id;

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign is_arrive = (op_q == OP_ARRIVE);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (idx_q == LAST_IDX) state_d = S_TAIL;
			end
			S_TAIL:  state_d = S_RUN;
			S_RUN:   state_d = S_TAT;
			S_TAT:   state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		rd_issue      = 1'b0;
		run_en        = 1'b0;
		tat_en        = 1'b0;
		done_fire     = 1'b0;
		case (state_q)
			S_IDLE: s_axis_tready = 1'b1;
			S_SCAN: rd_issue      = 1'b1;
			S_RUN:  run_en        = 1'b1;
			S_TAT:  tat_en        = 1'b1;
			S_DONE: done_fire     = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Quantum register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANT_W'(1);
		end else if (cfg_wen) begin
			quantum_q <= cfg_wdata;
		end
	end

	// Latch the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= s_axis_tuser[0];
			id_q    <= s_axis_tdata[7:0];
			burst_q <= s_axis_tdata[23:8];
		end
	end

	// Scan address and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			idx_s1    <= '0;
			cmp_en_s1 <= 1'b0;
		end else begin
			if (accept) begin
				idx_q <= '0;
			end else if (rd_issue) begin
				idx_q <= idx_q + SLOT_W'(1);
			end
			idx_s1    <= idx_q;
			cmp_en_s1 <= rd_issue;
		end
	end

	srtf_slot_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (wr_rec),
		.raddr (idx_q),
		.rdata (rd_rec)
	);

	srtf_pick u_pick (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (accept),
		.cmp_en     (cmp_en_s1),
		.cand_valid (slot_valid_q[idx_s1]),
		.cand_idx   (idx_s1),
		.cand_rec   (rd_rec),
		.last_slot  (last_slot_q),
		.pick       (pick),
		.best_rec   (best_rec)
	);

	// Run length and saturating clock advance
	always_comb begin
		q16     = (quantum_q == '0) ? BURST_W'(1) : BURST_W'(quantum_q);
		run16   = (q16 < best_rec.remaining) ? q16 : best_rec.remaining;
		rem_new = best_rec.remaining - run16;
		if (is_arrive) begin
			inc = '0;
		end else if (pick.found) begin
			inc = TIME_W'(run16);
		end else begin
			inc = TIME_W'(1);
		end
		sum       = {1'b0, clock_time_q} + {1'b0, inc};
		clock_new = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
	end

	// Table write for a new job or a run job
	always_comb begin
		mem_we    = run_en && (is_arrive ? pick.free_found : pick.found);
		mem_waddr = is_arrive ? pick.free_idx : pick.idx;
		if (is_arrive) begin
			wr_rec.job       = id_q;
			wr_rec.remaining = burst_q;
			wr_rec.burst     = burst_q;
			wr_rec.arrived   = clock_time_q;
			wr_rec.order     = order_q;
		end else begin
			wr_rec           = best_rec;
			wr_rec.remaining = rem_new;
		end
	end

	// Scheduler state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			order_q      <= '0;
			clock_time_q <= '0;
			last_slot_q  <= NO_SLOT;
		end else if (run_en) begin
			clock_time_q <= clock_new;
			if (is_arrive) begin
				if (pick.free_found) begin
					slot_valid_q[pick.free_idx] <= 1'b1;
					order_q <= order_q + ORDER_W'(1);
				end
			end else if (pick.found) begin
				if (rem_new == '0) begin
					slot_valid_q[pick.idx] <= 1'b0;
					last_slot_q <= NO_SLOT;
				end else begin
					last_slot_q <= LAST_W'(pick.idx);
				end
			end
		end
	end

	// Remaining time and turnaround
	always_ff @(posedge clk) begin
		if (run_en) begin
			rem_new_q <= rem_new;
		end
		if (tat_en) begin
			tat_q <= clock_time_q - best_rec.arrived;
		end
	end

	// Result fields
	always_comb begin
		wait_val = (tat_q >= TIME_W'(best_rec.burst)) ? tat_q - TIME_W'(best_rec.burst) : '0;
		if (is_arrive) begin
			status = pick.free_found ? STAT_ACCEPTED : STAT_REJECTED;
			run_id = id_q;
		end else if (!pick.found) begin
			status = STAT_IDLE;
			run_id = '0;
		end else begin
			status = (rem_new_q == '0) ? STAT_COMPLETED : STAT_RAN;
			run_id = best_rec.job;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			out_user_q         <= status;
			out_data_q[7:0]    <= run_id;
			out_data_q[39:8]   <= clock_time_q;
			out_data_q[55:40]  <= (status == STAT_RAN) ? rem_new_q : '0;
			out_data_q[87:56]  <= (status == STAT_COMPLETED) ? tat_q : '0;
			out_data_q[119:88] <= (status == STAT_COMPLETED) ? wait_val : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

### tb/sv/srtf_job_scheduler_test.sv
module srtf_job_scheduler_test;

	import srtf_pkg::*;

	// One result item, fields in report order
	typedef struct packed {
		status_t            status;
		logic [ID_W-1:0]    run_id;
		logic [TIME_W-1:0]  time_now;
		logic [BURST_W-1:0] time_left;
		logic [TIME_W-1:0]  turnaround;
		logic [TIME_W-1:0]  waiting;
	} outcome_t;

	// One row of the opening script; want is used only when known is set
	typedef struct {
		op_t                op;
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
		bit                 known;
		outcome_t           want;
	} script_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [23:0]  s_axis_tdata;   // job_id, burst
	logic [0:0]   s_axis_tuser;   // op
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [119:0] m_axis_tdata;   // run_id, time_now, time_left, turnaround, waiting
	logic [2:0]   m_axis_tuser;   // status
	logic         cfg_wen;
	logic [7:0]   cfg_wdata;      // quantum

	// Mirror of the ready table and scheduler state
	bit                 slot_busy  [MAX_JOBS];
	logic [ID_W-1:0]    slot_id    [MAX_JOBS];
	logic [BURST_W-1:0] slot_left  [MAX_JOBS];
	logic [BURST_W-1:0] slot_size  [MAX_JOBS];
	logic [TIME_W-1:0]  slot_start [MAX_JOBS];
	logic [ORDER_W-1:0] slot_seq   [MAX_JOBS];
	logic [ORDER_W-1:0] next_seq;
	logic [TIME_W-1:0]  sched_clock;
	logic [LAST_W-1:0]  prev_slot;
	logic [QUANT_W-1:0] cur_quantum;

	outcome_t outcome_q [$];
	int       failures;
	bit       steady;
	bit       hold_off;

	// Opening script: empty dispatch, field extremes, zero burst, both tie-breaks
	script_row_t script [14] = '{
		'{OP_DISPATCH, 8'h00, 16'h0000, 1'b1, {STAT_IDLE, 8'h00, 32'd1, 16'd0, 32'd0, 32'd0}},
		'{OP_ARRIVE,   8'h00, 16'h0001, 1'b1,
			{STAT_ACCEPTED, 8'h00, 32'd1, 16'd0, 32'd0, 32'd0}},
		'{OP_ARRIVE,   8'hFF, 16'hFFFF, 1'b1,
			{STAT_ACCEPTED, 8'hFF, 32'd1, 16'd0, 32'd0, 32'd0}},
		'{OP_ARRIVE,   8'hA5, 16'h0000, 1'b1,
			{STAT_ACCEPTED, 8'hA5, 32'd1, 16'd0, 32'd0, 32'd0}},
		'{OP_DISPATCH, 8'hFF, 16'hFFFF, 1'b0, '0},
		'{OP_DISPATCH, 8'h5A, 16'h1234, 1'b0, '0},
		'{OP_DISPATCH, 8'h00, 16'h0000, 1'b0, '0},
		'{OP_ARRIVE,   8'h20, 16'h0002, 1'b0, '0},
		'{OP_DISPATCH, 8'h00, 16'h0000, 1'b0, '0},
		'{OP_ARRIVE,   8'h21, 16'h0001, 1'b0, '0},
		'{OP_DISPATCH, 8'h00, 16'h0000, 1'b0, '0},
		'{OP_ARRIVE,   8'h22, 16'h0001, 1'b0, '0},
		'{OP_DISPATCH, 8'h00, 16'h0000, 1'b0, '0},
		'{OP_DISPATCH, 8'h00, 16'h0000, 1'b0, '0}
	};

	srtf_job_scheduler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [TIME_W-1:0] clock_add(logic [TIME_W-1:0] t, logic [TIME_W-1:0] d);
		logic [TIME_W:0] s;
		s = {1'b0, t} + {1'b0, d};
		return s[TIME_W] ? '1 : s[TIME_W-1:0];
	endfunction

	// Shorter remaining time wins, then the job that ran last, then earlier arrival
	function automatic bit preferred(int a, int b);
		if (slot_left[a] != slot_left[b])
			return slot_left[a] < slot_left[b];
		if (a == int'(prev_slot))
			return 1'b1;
		if (b == int'(prev_slot))
			return 1'b0;
		return slot_seq[a] < slot_seq[b];
	endfunction

	// Apply one item to the mirror and return the result it causes
	function automatic outcome_t schedule_step(op_t op, logic [ID_W-1:0] id,
			logic [BURST_W-1:0] burst);
		outcome_t           r;
		int                 pick;
		int                 spot;
		logic [BURST_W-1:0] step;
		logic [TIME_W-1:0]  span;
		r = '0;
		pick = MAX_JOBS;
		spot = MAX_JOBS;
		if (op == OP_ARRIVE) begin
			// take the lowest free slot
			for (int i = MAX_JOBS - 1; i >= 0; i--)
				if (!slot_busy[i])
					spot = i;
			r.run_id = id;
			if (spot == MAX_JOBS) begin
				r.status = STAT_REJECTED;
			end else begin
				slot_busy[spot]  = 1'b1;
				slot_id[spot]    = id;
				slot_left[spot]  = burst;
				slot_size[spot]  = burst;
				slot_start[spot] = sched_clock;
				slot_seq[spot]   = next_seq;
				next_seq         = next_seq + 1'b1;
				r.status         = STAT_ACCEPTED;
			end
		end else begin
			for (int i = 0; i < MAX_JOBS; i++)
				if (slot_busy[i] && (pick == MAX_JOBS || preferred(i, pick)))
					pick = i;
			if (pick == MAX_JOBS) begin
				sched_clock = clock_add(sched_clock, 32'd1);
				r.status = STAT_IDLE;
			end else begin
				// a zero quantum still runs one unit
				step = (cur_quantum == '0) ? 16'd1 : 16'(cur_quantum);
				if (slot_left[pick] < step)
					step = slot_left[pick];
				sched_clock = clock_add(sched_clock, 32'(step));
				slot_left[pick] = slot_left[pick] - step;
				r.run_id = slot_id[pick];
				if (slot_left[pick] == '0) begin
					slot_busy[pick] = 1'b0;
					prev_slot = NO_SLOT;
					span = sched_clock - slot_start[pick];
					r.turnaround = span;
					r.waiting = (span >= 32'(slot_size[pick])) ? span - 32'(slot_size[pick]) : '0;
					r.status = STAT_COMPLETED;
				end else begin
					prev_slot = LAST_W'(pick);
					r.time_left = slot_left[pick];
					r.status = STAT_RAN;
				end
			end
		end
		r.time_now = sched_clock;
		return r;
	endfunction

	task automatic log_fault(string msg);
		failures++;
		if (failures <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// Offer one item after a random gap and queue its result once it is taken
	task automatic send_item(op_t op, logic [ID_W-1:0] id, logic [BURST_W-1:0] burst,
			bit known, outcome_t want);
		int       gap;
		outcome_t r;
		gap = steady ? 0 : $urandom_range(0, 19);
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {burst, id};
		do @(posedge clk); while (!s_axis_tready);
		r = schedule_step(op, id, burst);
		outcome_q.push_back(known ? want : r);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic write_quantum(logic [QUANT_W-1:0] q);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= q;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		cur_quantum = q;
	endtask

	// Receiver: random stalls per item, one long hold-off on request
	initial begin
		int pause;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off) begin
				pause = 400;
				hold_off = 1'b0;
			end else begin
				pause = steady ? 0 : $urandom_range(0, 19);
			end
			repeat (pause) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
			end
			@(negedge clk);
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Compare each delivered result with the oldest one waiting
	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8], m_axis_tdata[55:40],
				m_axis_tdata[87:56], m_axis_tdata[119:88]};
			if (outcome_q.size() == 0) begin
				log_fault($sformatf("result with none pending: status %0d id %0d",
					got.status, got.run_id));
			end else begin
				want = outcome_q.pop_front();
				if (got !== want)
					log_fault($sformatf({"mismatch: exp st %0d id %0d now %0d left %0d tat %0d ",
						"wait %0d, got st %0d id %0d now %0d left %0d tat %0d wait %0d"},
						want.status, want.run_id, want.time_now, want.time_left,
						want.turnaround, want.waiting, got.status, got.run_id, got.time_now,
						got.time_left, got.turnaround, got.waiting));
			end
		end
	end

	initial begin
		int                 arrive_pct;
		int                 pick;
		int                 quanta [8];
		op_t                op;
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_wen       = 1'b0;
		cfg_wdata     = '0;
		steady        = 1'b0;
		hold_off      = 1'b0;
		failures      = 0;
		foreach (slot_busy[i])
			slot_busy[i] = 1'b0;
		next_seq    = '0;
		sched_clock = '0;
		prev_slot   = NO_SLOT;
		cur_quantum = 8'd1;
		quanta = '{255, 0, 1, -1, 255, -1, -1, 2};

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		foreach (script[i])
			send_item(script[i].op, script[i].id, script[i].burst, script[i].known,
				script[i].want);

		// Random phases, each under its own quantum with the block drained first
		for (int phase = 0; phase < 8; phase++) begin
			stop_sending();
			while (outcome_q.size() != 0) @(posedge clk);
			repeat (4) @(negedge clk);
			write_quantum((quanta[phase] < 0) ? QUANT_W'($urandom_range(1, 255))
				: QUANT_W'(quanta[phase]));
			steady   = (phase == 5);
			hold_off = (phase == 3);
			if (phase == 2)
				arrive_pct = 90;
			else if (phase == 6)
				arrive_pct = 15;
			else
				arrive_pct = $urandom_range(30, 70);
			repeat (86) begin
				op = ($urandom_range(1, 100) <= arrive_pct) ? OP_ARRIVE : OP_DISPATCH;
				id = $urandom_range(0, 255);
				pick = $urandom_range(0, 99);
				if (pick < 80)
					burst = $urandom_range(1, 40);
				else if (pick < 97)
					burst = $urandom_range(41, 1000);
				else
					burst = $urandom_range(1, 65535);
				send_item(op, id, burst, 1'b0, '0);
			end
		end

		// Drain, then allow the pipeline to settle
		stop_sending();
		for (int n = 0; n < 20000 && outcome_q.size() != 0; n++)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (outcome_q.size() != 0)
			log_fault($sformatf("%0d results never delivered", outcome_q.size()));

		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### files.f
hdl/srtf_pkg.sv
hdl/srtf_slot_mem.sv
hdl/srtf_pick.sv
hdl/srtf_job_scheduler.sv
tb/sv/srtf_job_scheduler_test.sv
